// ===== rtl/spmu_pkg.sv =====
// Shared constants, types and table functions for the star proper-motion update unit.
`default_nettype none

package spmu_pkg;

   // Number of CORDIC rotation and vectoring cells in each chain (range 16 to 48).
   localparam int CORDIC_STEPS = 32;

   // Number of square-root cells, one result bit each.
   localparam int SQRT_STEPS = 32;

   // Width of the CORDIC x and y datapath.
   localparam int XY_W = 40;

   // Angle constants in Q60 radians.
   localparam logic signed [63:0] PI_Q60      = 64'sh3243F6A8885A308D;
   localparam logic signed [63:0] TWO_PI_Q60  = 64'sh6487ED5110B4611A;
   localparam logic signed [63:0] HALF_PI_Q60 = 64'sh1921FB54442D1846;

   // Reciprocal of the CORDIC gain in Q30.
   localparam logic signed [XY_W-1:0] INV_GAIN_Q30 = XY_W'(64'h26DD3B6A);

   // Output limits in Q28 radians.
   localparam logic signed [63:0] RA_MAX  = 64'sd1686629713;
   localparam logic signed [63:0] DEC_MAX = 64'sd421657428;

   // Radial velocity scale: (365.25 * 86400 / 149597870) * 4.8481368111e-6 in Q60.
   localparam logic [127:0] VFR_NUM = 128'd15299556222996936;
   localparam logic [127:0] VFR_TMP = (VFR_NUM << 60) / 128'd1000000000000000;
   localparam logic signed [63:0] VFR_Q60 = 64'(VFR_TMP / 128'd14959787);

   // Static setup of one CORDIC cell.
   typedef struct packed {
      logic                vec;
      logic [5:0]          idx;
      logic signed [63:0]  angle;
   } cell_cfg_type;

   // Arctangent of 2^-i in Q60, from the truncated Taylor series.
   function automatic logic signed [63:0] atan_entry(input int i);
      logic signed [63:0] sum;
      logic [63:0]        t;
      int                 k;
      int                 e;
      sum = 64'sd0;
      if (i == 0) begin
         sum = PI_Q60 >>> 2;
      end else begin
         for (k = 0; i * (2 * k + 1) <= 60; k++) begin
            e = 60 - i * (2 * k + 1);
            t = (64'd1 << e) / 64'(2 * k + 1);
            if (k % 2 == 1) begin
               sum = sum - $signed(t);
            end else begin
               sum = sum + $signed(t);
            end
         end
      end
      return sum;
   endfunction

endpackage

`default_nettype wire

// ===== rtl/spmu_mul.sv =====
// Two-stage signed multiplier with a shift of the magnitude (truncation toward zero) and magnitude saturation at 2^62.
`default_nettype none

module spmu_mul (
   input  wire logic               clock,
   input  wire logic               enable,
   input  wire logic signed [63:0] a,
   input  wire logic signed [63:0] b,
   input  wire logic [5:0]         shift,
   output logic signed [63:0]      p_ff
);

   logic [63:0]        mag_a;
   logic [63:0]        mag_b;
   logic               neg_in;
   logic [63:0]        part_in [4];
   logic [63:0]        part_ff [4];
   logic               neg_ff;
   logic [127:0]       prod;
   logic [127:0]       shifted;
   logic [63:0]        sat;
   logic signed [63:0] p_in;

   // First stage: sign and magnitudes, four 32 by 32 partial products.
   always_comb begin
      mag_a      = a[63] ? 64'(-a) : 64'(a);
      mag_b      = b[63] ? 64'(-b) : 64'(b);
      neg_in     = a[63] ^ b[63];
      part_in[0] = 64'(mag_a[31:0])  * 64'(mag_b[31:0]);
      part_in[1] = 64'(mag_a[31:0])  * 64'(mag_b[63:32]);
      part_in[2] = 64'(mag_a[63:32]) * 64'(mag_b[31:0]);
      part_in[3] = 64'(mag_a[63:32]) * 64'(mag_b[63:32]);
   end

   // Second stage: sum, shift, saturate and restore the sign.
   always_comb begin
      prod = {part_ff[3], 64'd0}
           + {32'd0, part_ff[1], 32'd0}
           + {32'd0, part_ff[2], 32'd0}
           + {64'd0, part_ff[0]};
      shifted = prod >> shift;
      sat     = (shifted > 128'h4000000000000000) ? 64'h4000000000000000 : shifted[63:0];
      p_in    = neg_ff ? -$signed(sat) : $signed(sat);
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         part_ff <= part_in;
         neg_ff  <= neg_in;
         p_ff    <= p_in;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/spmu_cordic_cell.sv =====
// One CORDIC micro-rotation cell, in rotation or vectoring mode.
`default_nettype none

module spmu_cordic_cell (
   input  wire logic                               clock,
   input  wire logic                               enable,
   input  wire spmu_pkg::cell_cfg_type             cfg,
   input  wire logic signed [spmu_pkg::XY_W-1:0]   x_d,
   input  wire logic signed [spmu_pkg::XY_W-1:0]   y_d,
   input  wire logic signed [63:0]                 z_d,
   output logic signed [spmu_pkg::XY_W-1:0]        x_ff,
   output logic signed [spmu_pkg::XY_W-1:0]        y_ff,
   output logic signed [63:0]                      z_ff
);

   logic signed [spmu_pkg::XY_W-1:0] xs;
   logic signed [spmu_pkg::XY_W-1:0] ys;
   logic signed [spmu_pkg::XY_W-1:0] x_in;
   logic signed [spmu_pkg::XY_W-1:0] y_in;
   logic signed [63:0]               z_in;
   logic                             up;

   // Rotation mode steers by the residual angle, vectoring mode by the sign of y.
   always_comb begin
      xs = x_d >>> cfg.idx;
      ys = y_d >>> cfg.idx;
      up = cfg.vec ? y_d[spmu_pkg::XY_W-1] : !z_d[63];
      if (up) begin
         x_in = x_d - ys;
         y_in = y_d + xs;
         z_in = z_d - cfg.angle;
      end else begin
         x_in = x_d + ys;
         y_in = y_d - xs;
         z_in = z_d + cfg.angle;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         x_ff <= x_in;
         y_ff <= y_in;
         z_ff <= z_in;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/spmu_sqrt_cell.sv =====
// One restoring square-root cell that settles one result bit.
`default_nettype none

module spmu_sqrt_cell (
   input  wire logic        clock,
   input  wire logic        enable,
   input  wire logic [4:0]  idx,
   input  wire logic [63:0] v_d,
   input  wire logic [63:0] res_d,
   output logic [63:0]      v_ff,
   output logic [63:0]      res_ff
);

   logic [63:0] bit_v;
   logic [63:0] trial;
   logic [63:0] v_in;
   logic [63:0] res_in;

   // Trial subtraction of res + 4^(31-idx).
   always_comb begin
      bit_v = 64'd1 << (7'd62 - 7'({idx, 1'b0}));
      trial = res_d + bit_v;
      if (v_d >= trial) begin
         v_in   = v_d - trial;
         res_in = (res_d >> 1) + bit_v;
      end else begin
         v_in   = v_d;
         res_in = res_d >> 1;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         v_ff   <= v_in;
         res_ff <= res_in;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/star_proper_motion_update_unit.sv =====
// Top level of the star proper-motion update unit: a fully pipelined chain of cells.
`default_nettype none

// One star per clock enters and one result per clock leaves once the pipeline is full.
// The data passes through the two CORDIC sine/cosine chains, the 32-cell square-root
// chain and the two CORDIC atan2 chains that follow it. The whole pipeline advances
// together; it holds only when a result sits in the output register and is not taken.

module star_proper_motion_update_unit (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   output logic              req_tready,
   // ra_start[31:0], dec_start[61:32], pm_ra[93:62], pm_dec[125:94],
   // parallax_arcsec[157:126], radial_velocity[189:158], epoch_start[221:190],
   // epoch_end[253:222], zero fill [255:254]
   input  wire logic [255:0] req_tdata,
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   // ra_end[30:0], dec_end[60:31], zero fill [63:61]
   output logic [63:0]       rsp_tdata
);

   localparam int N        = spmu_pkg::CORDIC_STEPS;
   localparam int S        = spmu_pkg::SQRT_STEPS;
   localparam int W        = spmu_pkg::XY_W;
   localparam int LAT      = 29 + S + 2 * N;
   localparam int SIDE_LEN = 9 + N;
   localparam int NORM_N   = 12;

   typedef struct packed {
      logic signed [31:0] pmr;
      logic signed [31:0] pmd;
      logic signed [32:0] dt;
   } side_type;

   typedef struct packed {
      logic signed [63:0] x;
      logic signed [63:0] y;
      logic signed [63:0] z;
   } vec3_type;

   typedef struct packed {
      logic pole;
      logic zero_z;
   } flag_type;

   // Largest component magnitude of a vector.
   function automatic logic [63:0] max_mag(input vec3_type v);
      logic [63:0] mx;
      logic [63:0] my;
      logic [63:0] mz;
      logic [63:0] m;
      mx = v.x[63] ? 64'(-v.x) : 64'(v.x);
      my = v.y[63] ? 64'(-v.y) : 64'(v.y);
      mz = v.z[63] ? 64'(-v.z) : 64'(v.z);
      m  = mx;
      if (my > m) begin
         m = my;
      end
      if (mz > m) begin
         m = mz;
      end
      return m;
   endfunction

   // Reduce an angle into [-pi, pi] by one step of 2pi.
   function automatic logic signed [63:0] wrap_pi(input logic signed [63:0] a);
      logic signed [63:0] r;
      if (a > spmu_pkg::PI_Q60) begin
         r = a - spmu_pkg::TWO_PI_Q60;
      end else if (a < -spmu_pkg::PI_Q60) begin
         r = a + spmu_pkg::TWO_PI_Q60;
      end else begin
         r = a;
      end
      return r;
   endfunction

   logic               adv;
   logic [LAT-1:0]     vld_ff;

   // Input stage.
   logic signed [31:0] in_ra_ff;
   logic signed [29:0] in_dec_ff;
   logic [31:0]        plx_ff;
   logic signed [31:0] rv_ff;
   side_type           side_in;
   side_type           side_ff [SIDE_LEN];

   // Angle reduction and radial product.
   logic signed [63:0] red_ra_ff;
   logic signed [63:0] red_dec_ff;
   logic signed [63:0] rvplx_ff;
   logic signed [64:0] rvplx_in;

   // Rotation chains.
   logic signed [W-1:0] rx [N+1];
   logic signed [W-1:0] ry [N+1];
   logic signed [63:0]  rz [N+1];
   logic signed [W-1:0] dx [N+1];
   logic signed [W-1:0] dy [N+1];
   logic signed [63:0]  dz [N+1];
   logic [1:0]          flip_in;
   logic [1:0]          flip_ff [N+1];
   logic signed [63:0]  ra_fold;
   logic signed [63:0]  dec_fold;

   // Radial term.
   logic signed [63:0]  w_mul;
   logic signed [63:0]  w_ff [N+2];

   // Sine and cosine.
   logic signed [63:0]  cra_ff;
   logic signed [63:0]  sra_ff;
   logic signed [63:0]  cdec_ff;
   logic signed [63:0]  sdec_ff;
   logic signed [63:0]  sdec_d1_ff;
   logic signed [63:0]  sdec_d2_ff;

   // Products.
   logic signed [63:0]  pos0;
   logic signed [63:0]  pos1;
   logic signed [63:0]  cs;
   logic signed [63:0]  ss;
   logic signed [63:0]  pc;
   logic signed [63:0]  pc_d1_ff;
   logic signed [63:0]  pc_d2_ff;
   logic signed [63:0]  ta;
   logic signed [63:0]  tb;
   logic signed [63:0]  tc;
   logic signed [63:0]  td;
   logic signed [63:0]  te;
   logic signed [63:0]  tf;
   logic signed [63:0]  tg;
   vec3_type            posd_ff [5];
   vec3_type            pos_in;
   logic signed [63:0]  em0_ff;
   logic signed [63:0]  em1_ff;
   logic signed [63:0]  em2_ff;
   logic signed [63:0]  mv0;
   logic signed [63:0]  mv1;
   logic signed [63:0]  mv2;
   logic signed [63:0]  dt64;

   // Normalization.
   vec3_type            nv_ff [NORM_N+1];
   vec3_type            nv_in [NORM_N];

   // Square root of x^2 + y^2.
   logic signed [63:0]  sq0_ff;
   logic signed [63:0]  sq1_ff;
   logic [63:0]         sum_ff;
   logic [63:0]         sv [S+1];
   logic [63:0]         sres [S+1];
   vec3_type            pd_ff [S+2];

   // Vectoring chains.
   logic signed [W-1:0] ax [N+1];
   logic signed [W-1:0] ay [N+1];
   logic signed [63:0]  az [N+1];
   logic signed [W-1:0] bx [N+1];
   logic signed [W-1:0] by [N+1];
   logic signed [63:0]  bz [N+1];
   flag_type            fl_in;
   flag_type            fl_ff [N+1];
   logic signed [W-1:0] px_w;
   logic signed [W-1:0] py_w;
   logic signed [W-1:0] pz_w;
   logic signed [W-1:0] rxy_w;

   // Final conversion.
   logic signed [63:0]  ra_w_in;
   logic signed [63:0]  ra_w_ff;
   logic signed [63:0]  dec_w_ff;
   logic signed [63:0]  ra_s;
   logic signed [63:0]  dec_s;
   logic [30:0]         ra_end_in;
   logic [29:0]         dec_end_in;
   logic [30:0]         ra_end_ff;
   logic [29:0]         dec_end_ff;

   // The pipeline moves whenever the output register is free or being drained.
   assign adv        = !vld_ff[LAT-1] || rsp_tready;
   assign req_tready = adv;
   assign rsp_tvalid = vld_ff[LAT-1];
   assign rsp_tdata  = {3'd0, dec_end_ff, ra_end_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= {vld_ff[LAT-2:0], req_tvalid};
      end
   end

   // Input capture and epoch difference.
   always_comb begin
      side_in.pmr = $signed(req_tdata[93:62]);
      side_in.pmd = $signed(req_tdata[125:94]);
      side_in.dt  = 33'($signed(req_tdata[253:222])) - 33'($signed(req_tdata[221:190]));
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         in_ra_ff   <= $signed(req_tdata[31:0]);
         in_dec_ff  <= $signed(req_tdata[61:32]);
         plx_ff     <= req_tdata[157:126];
         rv_ff      <= $signed(req_tdata[189:158]);
         side_ff[0] <= side_in;
         for (int i = 1; i < SIDE_LEN; i++) begin
            side_ff[i] <= side_ff[i-1];
         end
      end
   end

   // Range reduction by 2pi, and the velocity times parallax product.
   assign rvplx_in = 65'(rv_ff) * $signed({33'd0, plx_ff});

   always_ff @(posedge clock) begin
      if (adv) begin
         red_ra_ff  <= wrap_pi({in_ra_ff, 32'd0});
         red_dec_ff <= wrap_pi({{2{in_dec_ff[29]}}, in_dec_ff, 32'd0});
         rvplx_ff   <= rvplx_in[63:0];
      end
   end

   // Fold into [-pi/2, pi/2] by a step of pi that negates sine and cosine.
   always_comb begin
      flip_in  = 2'b00;
      ra_fold  = red_ra_ff;
      dec_fold = red_dec_ff;
      if (red_ra_ff > spmu_pkg::HALF_PI_Q60) begin
         ra_fold    = red_ra_ff - spmu_pkg::PI_Q60;
         flip_in[0] = 1'b1;
      end else if (red_ra_ff < -spmu_pkg::HALF_PI_Q60) begin
         ra_fold    = red_ra_ff + spmu_pkg::PI_Q60;
         flip_in[0] = 1'b1;
      end
      if (red_dec_ff > spmu_pkg::HALF_PI_Q60) begin
         dec_fold   = red_dec_ff - spmu_pkg::PI_Q60;
         flip_in[1] = 1'b1;
      end else if (red_dec_ff < -spmu_pkg::HALF_PI_Q60) begin
         dec_fold   = red_dec_ff + spmu_pkg::PI_Q60;
         flip_in[1] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rx[0]      <= spmu_pkg::INV_GAIN_Q30;
         ry[0]      <= '0;
         rz[0]      <= ra_fold;
         dx[0]      <= spmu_pkg::INV_GAIN_Q30;
         dy[0]      <= '0;
         dz[0]      <= dec_fold;
         flip_ff[0] <= flip_in;
         for (int i = 1; i <= N; i++) begin
            flip_ff[i] <= flip_ff[i-1];
         end
      end
   end

   // Sine/cosine rotation chains for RA and Dec.
   for (genvar g = 0; g < N; g++) begin : g_rot
      localparam spmu_pkg::cell_cfg_type CFG = '{
         vec: 1'b0, idx: 6'(g), angle: spmu_pkg::atan_entry(g)};

      spmu_cordic_cell u_ra (
         .clock (clock), .enable (adv), .cfg (CFG),
         .x_d (rx[g]), .y_d (ry[g]), .z_d (rz[g]),
         .x_ff (rx[g+1]), .y_ff (ry[g+1]), .z_ff (rz[g+1])
      );

      spmu_cordic_cell u_dec (
         .clock (clock), .enable (adv), .cfg (CFG),
         .x_d (dx[g]), .y_d (dy[g]), .z_d (dz[g]),
         .x_ff (dx[g+1]), .y_ff (dy[g+1]), .z_ff (dz[g+1])
      );
   end

   // Radial term w = rv * plx * VFR, kept until the motion products.
   spmu_mul u_w (
      .clock (clock), .enable (adv), .a (rvplx_ff), .b (spmu_pkg::VFR_Q60),
      .shift (6'd49), .p_ff (w_mul)
   );

   always_ff @(posedge clock) begin
      if (adv) begin
         w_ff[0] <= w_mul;
         for (int i = 1; i < N + 2; i++) begin
            w_ff[i] <= w_ff[i-1];
         end
      end
   end

   // Apply the fold sign to the chain outputs.
   always_ff @(posedge clock) begin
      if (adv) begin
         cra_ff     <= flip_ff[N][0] ? -64'(rx[N]) : 64'(rx[N]);
         sra_ff     <= flip_ff[N][0] ? -64'(ry[N]) : 64'(ry[N]);
         cdec_ff    <= flip_ff[N][1] ? -64'(dx[N]) : 64'(dx[N]);
         sdec_ff    <= flip_ff[N][1] ? -64'(dy[N]) : 64'(dy[N]);
         sdec_d1_ff <= sdec_ff;
         sdec_d2_ff <= sdec_d1_ff;
      end
   end

   // Unit vector and cross products.
   spmu_mul u_pos0 (.clock (clock), .enable (adv), .a (cra_ff), .b (cdec_ff),
                    .shift (6'd30), .p_ff (pos0));
   spmu_mul u_pos1 (.clock (clock), .enable (adv), .a (sra_ff), .b (cdec_ff),
                    .shift (6'd30), .p_ff (pos1));
   spmu_mul u_cs   (.clock (clock), .enable (adv), .a (cra_ff), .b (sdec_ff),
                    .shift (6'd30), .p_ff (cs));
   spmu_mul u_ss   (.clock (clock), .enable (adv), .a (sra_ff), .b (sdec_ff),
                    .shift (6'd30), .p_ff (ss));
   spmu_mul u_pc   (.clock (clock), .enable (adv), .a (64'(side_ff[3+N].pmd)),
                    .b (cdec_ff), .shift (6'd24), .p_ff (pc));

   // Space-motion terms.
   spmu_mul u_ta (.clock (clock), .enable (adv), .a (64'(side_ff[5+N].pmr)), .b (pos1),
                  .shift (6'd24), .p_ff (ta));
   spmu_mul u_tb (.clock (clock), .enable (adv), .a (64'(side_ff[5+N].pmd)), .b (cs),
                  .shift (6'd24), .p_ff (tb));
   spmu_mul u_tc (.clock (clock), .enable (adv), .a (w_ff[N+1]), .b (pos0),
                  .shift (6'd30), .p_ff (tc));
   spmu_mul u_td (.clock (clock), .enable (adv), .a (64'(side_ff[5+N].pmr)), .b (pos0),
                  .shift (6'd24), .p_ff (td));
   spmu_mul u_te (.clock (clock), .enable (adv), .a (64'(side_ff[5+N].pmd)), .b (ss),
                  .shift (6'd24), .p_ff (te));
   spmu_mul u_tf (.clock (clock), .enable (adv), .a (w_ff[N+1]), .b (pos1),
                  .shift (6'd30), .p_ff (tf));
   spmu_mul u_tg (.clock (clock), .enable (adv), .a (w_ff[N+1]), .b (sdec_d2_ff),
                  .shift (6'd30), .p_ff (tg));

   assign pos_in = '{x: pos0, y: pos1, z: sdec_d2_ff};

   always_ff @(posedge clock) begin
      if (adv) begin
         pc_d1_ff   <= pc;
         pc_d2_ff   <= pc_d1_ff;
         posd_ff[0] <= pos_in;
         for (int i = 1; i < 5; i++) begin
            posd_ff[i] <= posd_ff[i-1];
         end
         em0_ff <= tc - ta - tb;
         em1_ff <= td - te + tf;
         em2_ff <= pc_d2_ff + tg;
      end
   end

   // Motion over the epoch difference.
   assign dt64 = 64'(side_ff[8+N].dt);

   spmu_mul u_mv0 (.clock (clock), .enable (adv), .a (dt64), .b (em0_ff),
                   .shift (6'd26), .p_ff (mv0));
   spmu_mul u_mv1 (.clock (clock), .enable (adv), .a (dt64), .b (em1_ff),
                   .shift (6'd26), .p_ff (mv1));
   spmu_mul u_mv2 (.clock (clock), .enable (adv), .a (dt64), .b (em2_ff),
                   .shift (6'd26), .p_ff (mv2));

   always_ff @(posedge clock) begin
      if (adv) begin
         nv_ff[0].x <= (posd_ff[4].x <<< 10) + mv0;
         nv_ff[0].y <= (posd_ff[4].y <<< 10) + mv1;
         nv_ff[0].z <= (posd_ff[4].z <<< 10) + mv2;
      end
   end

   // Normalization: binary right shifts while the largest magnitude stays at or above
   // 2^30, one more right shift if still too large, then binary left shifts up to 2^29.
   for (genvar g = 0; g < NORM_N; g++) begin : g_norm
      if (g < 6) begin : g_right
         localparam int SH = 32 >> g;
         vec3_type shr;
         always_comb begin
            shr.x    = nv_ff[g].x >>> SH;
            shr.y    = nv_ff[g].y >>> SH;
            shr.z    = nv_ff[g].z >>> SH;
            nv_in[g] = (max_mag(shr) >= 64'h40000000) ? shr : nv_ff[g];
         end
      end else if (g == 6) begin : g_last
         vec3_type shr;
         always_comb begin
            shr.x    = nv_ff[g].x >>> 1;
            shr.y    = nv_ff[g].y >>> 1;
            shr.z    = nv_ff[g].z >>> 1;
            nv_in[g] = (max_mag(nv_ff[g]) >= 64'h40000000) ? shr : nv_ff[g];
         end
      end else begin : g_left
         localparam int SH = 16 >> (g - 7);
         vec3_type shl;
         always_comb begin
            shl.x    = nv_ff[g].x <<< SH;
            shl.y    = nv_ff[g].y <<< SH;
            shl.z    = nv_ff[g].z <<< SH;
            nv_in[g] = (max_mag(nv_ff[g]) < (64'd1 << (30 - SH))) ? shl : nv_ff[g];
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            nv_ff[g+1] <= nv_in[g];
         end
      end
   end

   // Squares of x and y; magnitudes are below 2^30 here.
   always_ff @(posedge clock) begin
      if (adv) begin
         sq0_ff   <= 64'($signed(nv_ff[NORM_N].x[31:0])) * 64'($signed(nv_ff[NORM_N].x[31:0]));
         sq1_ff   <= 64'($signed(nv_ff[NORM_N].y[31:0])) * 64'($signed(nv_ff[NORM_N].y[31:0]));
         sum_ff   <= 64'(sq0_ff) + 64'(sq1_ff);
         pd_ff[0] <= nv_ff[NORM_N];
         for (int i = 1; i < S + 2; i++) begin
            pd_ff[i] <= pd_ff[i-1];
         end
      end
   end

   assign sv[0]   = sum_ff;
   assign sres[0] = '0;

   for (genvar g = 0; g < S; g++) begin : g_sqrt
      spmu_sqrt_cell u_cell (
         .clock (clock), .enable (adv), .idx (5'(g)),
         .v_d (sv[g]), .res_d (sres[g]), .v_ff (sv[g+1]), .res_ff (sres[g+1])
      );
   end

   // Pre-rotation by pi for a negative x, and the pole and zero-z flags.
   always_comb begin
      px_w         = W'(pd_ff[S+1].x);
      py_w         = W'(pd_ff[S+1].y);
      pz_w         = W'(pd_ff[S+1].z);
      rxy_w        = W'(sres[S]);
      fl_in.pole   = (pd_ff[S+1].x == '0) && (pd_ff[S+1].y == '0);
      fl_in.zero_z = (pd_ff[S+1].z == '0);
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         if (px_w[W-1]) begin
            ax[0] <= -px_w;
            ay[0] <= -py_w;
            az[0] <= py_w[W-1] ? -spmu_pkg::PI_Q60 : spmu_pkg::PI_Q60;
         end else begin
            ax[0] <= px_w;
            ay[0] <= py_w;
            az[0] <= '0;
         end
         if (rxy_w[W-1]) begin
            bx[0] <= -rxy_w;
            by[0] <= -pz_w;
            bz[0] <= pz_w[W-1] ? -spmu_pkg::PI_Q60 : spmu_pkg::PI_Q60;
         end else begin
            bx[0] <= rxy_w;
            by[0] <= pz_w;
            bz[0] <= '0;
         end
         fl_ff[0] <= fl_in;
         for (int i = 1; i <= N; i++) begin
            fl_ff[i] <= fl_ff[i-1];
         end
      end
   end

   // atan2 vectoring chains for RA and Dec.
   for (genvar g = 0; g < N; g++) begin : g_vec
      localparam spmu_pkg::cell_cfg_type CFG = '{
         vec: 1'b1, idx: 6'(g), angle: spmu_pkg::atan_entry(g)};

      spmu_cordic_cell u_ra (
         .clock (clock), .enable (adv), .cfg (CFG),
         .x_d (ax[g]), .y_d (ay[g]), .z_d (az[g]),
         .x_ff (ax[g+1]), .y_ff (ay[g+1]), .z_ff (az[g+1])
      );

      spmu_cordic_cell u_dec (
         .clock (clock), .enable (adv), .cfg (CFG),
         .x_d (bx[g]), .y_d (by[g]), .z_d (bz[g]),
         .x_ff (bx[g+1]), .y_ff (by[g+1]), .z_ff (bz[g+1])
      );
   end

   // Special cases and wrap of RA into [0, 2pi).
   always_comb begin
      ra_w_in = fl_ff[N].pole ? 64'sd0 : az[N];
      if (ra_w_in < 0) begin
         ra_w_in = ra_w_in + spmu_pkg::TWO_PI_Q60;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         ra_w_ff  <= ra_w_in;
         dec_w_ff <= fl_ff[N].zero_z ? 64'sd0 : bz[N];
      end
   end

   // Q60 to Q28 with floor, then clamp to the output ranges.
   always_comb begin
      ra_s  = ra_w_ff >>> 32;
      dec_s = dec_w_ff >>> 32;
      if (ra_s < 0) begin
         ra_end_in = '0;
      end else if (ra_s > spmu_pkg::RA_MAX) begin
         ra_end_in = 31'(spmu_pkg::RA_MAX);
      end else begin
         ra_end_in = ra_s[30:0];
      end
      if (dec_s > spmu_pkg::DEC_MAX) begin
         dec_end_in = 30'(spmu_pkg::DEC_MAX);
      end else if (dec_s < -spmu_pkg::DEC_MAX) begin
         dec_end_in = 30'(-spmu_pkg::DEC_MAX);
      end else begin
         dec_end_in = dec_s[29:0];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         ra_end_ff  <= ra_end_in;
         dec_end_ff <= dec_end_in;
      end
   end

   // Sum of squares of x and y, used to check the square-root chain.
   function automatic logic [63:0] pd_sum_check(input vec3_type v);
      logic signed [63:0] a;
      logic signed [63:0] b;
      a = v.x * v.x;
      b = v.y * v.y;
      return 64'(a + b);
   endfunction

   // A normalized nonzero vector has its largest magnitude in [2^29, 2^30).
   assert property (@(posedge clock) disable iff (reset)
      vld_ff[23+N] && (max_mag(nv_ff[NORM_N]) != '0)
      |-> (max_mag(nv_ff[NORM_N]) >= 64'h20000000) && (max_mag(nv_ff[NORM_N]) < 64'h40000000))
      else $error("normalized vector out of range");

   // Delivered RA stays within [0, 2pi).
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> ({33'd0, rsp_tdata[30:0]} <= 64'(spmu_pkg::RA_MAX)))
      else $error("ra_end above limit");

   // Delivered Dec stays within plus or minus pi/2.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (64'($signed(rsp_tdata[60:31])) <= spmu_pkg::DEC_MAX)
                  && (64'($signed(rsp_tdata[60:31])) >= -spmu_pkg::DEC_MAX))
      else $error("dec_end out of range");

   // The square-root result never exceeds the root of its operand.
   assert property (@(posedge clock) disable iff (reset)
      vld_ff[25+N+S] |-> (sres[S] * sres[S] <= pd_sum_check(pd_ff[S+1])))
      else $error("square root too large");

endmodule

`default_nettype wire
